### rtl/vbc_pkg.sv
// Shared types, constants and helper functions for the VCO band calibration block.
package vbc_pkg;

   localparam int CODE_WIDTH  = 5;
   localparam int COUNT_WIDTH = 12;
   localparam int STEP_WIDTH  = CODE_WIDTH - 1;

   localparam logic [CODE_WIDTH-1:0]  CODE_MAX   = {CODE_WIDTH{1'b1}};
   localparam logic [CODE_WIDTH-1:0]  CODE_START = CODE_WIDTH'(1) << (CODE_WIDTH - 1);
   localparam logic [STEP_WIDTH-1:0]  STEP_START = STEP_WIDTH'(1) << (STEP_WIDTH - 1);

   localparam logic [COUNT_WIDTH-1:0] TARGET_FIRST_RESET  = COUNT_WIDTH'(2001);
   localparam logic [COUNT_WIDTH-1:0] TARGET_SECOND_RESET = COUNT_WIDTH'(1834);

   // Item function codes.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_COUNT = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_TARGET_FIRST  = 1'b0;
   localparam logic CSR_TARGET_SECOND = 1'b1;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_LOWER  = 2'd1,
      PH_UPPER  = 2'd2
   } phase_type;

   typedef struct packed {
      logic                   busy;
      logic                   entry;
      phase_type              phase;
      logic [CODE_WIDTH-1:0]  search_code;
      logic [STEP_WIDTH-1:0]  step_size;
      logic [COUNT_WIDTH-1:0] centre_dev;
      logic [COUNT_WIDTH-1:0] lower_dev;
      logic [CODE_WIDTH-1:0]  code_first;
      logic [CODE_WIDTH-1:0]  code_second;
   } state_type;

   typedef struct packed {
      logic                  probe_request;
      logic [CODE_WIDTH-1:0] probe_code;
      logic                  probe_entry;
      logic                  accepted;
      logic                  done_res;
      logic [CODE_WIDTH-1:0] code_first;
      logic [CODE_WIDTH-1:0] code_second;
   } rsp_type;

   function automatic logic [CODE_WIDTH-1:0] lower_of(input logic [CODE_WIDTH-1:0] c);
      lower_of = (c == '0) ? '0 : c - CODE_WIDTH'(1);
   endfunction

   function automatic logic [CODE_WIDTH-1:0] upper_of(input logic [CODE_WIDTH-1:0] c);
      upper_of = (c == CODE_MAX) ? CODE_MAX : c + CODE_WIDTH'(1);
   endfunction

endpackage

### rtl/vco_band_calibration.sv
// Top level of the successive-approximation VCO band calibration block.
//
// Usage: send a start item (req_func = 0) to begin. Each result carries a
// probe request with the band code to apply; run the measurement and send the
// count back as a count item (req_func = 1). Per target the block probes four
// search codes (16, then steps of 8, 4, 2), takes a last step of 1 and probes
// the two neighbors of the final code, then keeps the code with the smallest
// deviation. After the second target a result with rsp_done_res = 1 reports
// both codes. Ignored items (start while busy, count while idle) still give
// one result, with rsp_accepted = 0.
// Path: a transferred item passes the input register, then the result
// register, which drives rsp_valid.
// Throughput: one item per cycle without rsp_stall; the calibration state
// updates as an item moves from the input register into the result register.
// Stall: rsp_stall holds the result register and the item behind it; req_stall
// rises only when both registers are full and the result is not taken.
// Reset (synchronous, active high) clears both registers, idles the sequence,
// zeroes the chosen codes and loads targets 2001 and 1834. Write csr_* only
// while the block is idle.
module vco_band_calibration (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_func,
   input  logic [vbc_pkg::COUNT_WIDTH-1:0]   req_measured_count,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_probe_request,
   output logic [vbc_pkg::CODE_WIDTH-1:0]    rsp_probe_code,
   output logic                              rsp_probe_entry,
   output logic                              rsp_accepted,
   output logic                              rsp_done_res,
   output logic [vbc_pkg::CODE_WIDTH-1:0]    rsp_code_first,
   output logic [vbc_pkg::CODE_WIDTH-1:0]    rsp_code_second,
   // Configuration port
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [vbc_pkg::COUNT_WIDTH-1:0]   csr_write_data
);

   // Input register
   logic                            in_valid_ff, in_valid_in;
   logic                            in_func_ff;
   logic [vbc_pkg::COUNT_WIDTH-1:0] in_count_ff;

   // Result register
   logic                            out_valid_ff, out_valid_in;
   vbc_pkg::rsp_type                out_ff;

   // Calibration state and targets
   vbc_pkg::state_type              state_ff, state_in;
   vbc_pkg::rsp_type                step_rsp;
   logic [vbc_pkg::COUNT_WIDTH-1:0] target_first_ff, target_second_ff;

   logic out_free;
   logic advance;
   logic req_take;

   // The result register can load when empty or when its result is taken now.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   vbc_step u_step (
      .state          (state_ff),
      .func           (in_func_ff),
      .measured_count (in_count_ff),
      .target_first   (target_first_ff),
      .target_second  (target_second_ff),
      .state_next     (state_in),
      .rsp            (step_rsp)
   );

   // Control: valid flags and calibration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff              <= 1'b0;
         out_valid_ff             <= 1'b0;
         state_ff.busy            <= 1'b0;
         state_ff.entry           <= 1'b0;
         state_ff.phase           <= vbc_pkg::PH_SEARCH;
         state_ff.search_code     <= vbc_pkg::CODE_START;
         state_ff.step_size       <= vbc_pkg::STEP_START;
         state_ff.centre_dev      <= '0;
         state_ff.lower_dev       <= '0;
         state_ff.code_first      <= '0;
         state_ff.code_second     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // Advance the sequence only as an item moves into the result register.
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Targets: load reset values, then take csr writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_first_ff  <= vbc_pkg::TARGET_FIRST_RESET;
         target_second_ff <= vbc_pkg::TARGET_SECOND_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            vbc_pkg::CSR_TARGET_FIRST:  target_first_ff  <= csr_write_data;
            vbc_pkg::CSR_TARGET_SECOND: target_second_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Payload: capture on transfer, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff  <= req_func;
         in_count_ff <= req_measured_count;
      end
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_probe_request = out_ff.probe_request;
   assign rsp_probe_code    = out_ff.probe_code;
   assign rsp_probe_entry   = out_ff.probe_entry;
   assign rsp_accepted      = out_ff.accepted;
   assign rsp_done_res      = out_ff.done_res;
   assign rsp_code_first    = out_ff.code_first;
   assign rsp_code_second   = out_ff.code_second;

   // An idle sequence always sits ready to search the first target.
   assert property (@(posedge clock) disable iff (reset)
      !state_ff.busy |-> (state_ff.phase == vbc_pkg::PH_SEARCH &&
                          state_ff.step_size == vbc_pkg::STEP_START &&
                          !state_ff.entry))
      else $error("idle sequence not parked at search start");

   // The search step is a single bit or zero.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(state_ff.step_size))
      else $error("step size not a power of two");

   // Done never comes with a probe, and ignored items give neither.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.done_res || !out_ff.accepted) |-> !out_ff.probe_request)
      else $error("probe issued with done or on ignored item");

   // The sequence state moves only when an item enters the result register.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without an item");

endmodule

### rtl/vbc_step.sv
// Next-state and result logic for one calibration item.
module vbc_step (
   input  vbc_pkg::state_type                  state,
   input  logic                                func,
   input  logic [vbc_pkg::COUNT_WIDTH-1:0]     measured_count,
   input  logic [vbc_pkg::COUNT_WIDTH-1:0]     target_first,
   input  logic [vbc_pkg::COUNT_WIDTH-1:0]     target_second,
   output vbc_pkg::state_type                  state_next,
   output vbc_pkg::rsp_type                    rsp
);

   logic [vbc_pkg::COUNT_WIDTH-1:0] target;
   logic [vbc_pkg::COUNT_WIDTH-1:0] dev;
   logic                            below;
   logic                            above;
   logic [vbc_pkg::CODE_WIDTH-1:0]  stepped_code;
   logic [vbc_pkg::STEP_WIDTH-1:0]  next_step;
   logic [vbc_pkg::CODE_WIDTH-1:0]  step_ext;
   logic [vbc_pkg::CODE_WIDTH-1:0]  code_low;
   logic [vbc_pkg::CODE_WIDTH-1:0]  code_high;
   logic [vbc_pkg::CODE_WIDTH-1:0]  pick;

   assign target    = state.entry ? target_second : target_first;
   assign below     = measured_count < target;
   assign above     = measured_count > target;
   assign dev       = below ? target - measured_count : measured_count - target;
   assign step_ext  = vbc_pkg::CODE_WIDTH'(state.step_size);
   assign next_step = state.step_size >> 1;
   assign code_low  = vbc_pkg::lower_of(state.search_code);
   assign code_high = vbc_pkg::upper_of(state.search_code);

   always_comb begin
      if (below) begin
         stepped_code = state.search_code + step_ext;
      end else if (above) begin
         stepped_code = state.search_code - step_ext;
      end else begin
         stepped_code = state.search_code;
      end
   end

   // Ties go to lower, then upper, then centre; dev is the upper deviation here.
   always_comb begin
      if (state.lower_dev <= state.centre_dev && state.lower_dev <= dev) begin
         pick = code_low;
      end else if (dev <= state.centre_dev && dev <= state.lower_dev) begin
         pick = code_high;
      end else begin
         pick = state.search_code;
      end
   end

   always_comb begin
      state_next        = state;
      rsp.probe_request = 1'b0;
      rsp.probe_code    = '0;
      rsp.probe_entry   = 1'b0;
      rsp.accepted      = 1'b0;
      rsp.done_res      = 1'b0;

      if (func == vbc_pkg::FUNC_START) begin
         if (!state.busy) begin
            state_next.busy        = 1'b1;
            state_next.entry       = 1'b0;
            state_next.phase       = vbc_pkg::PH_SEARCH;
            state_next.search_code = vbc_pkg::CODE_START;
            state_next.step_size   = vbc_pkg::STEP_START;
            rsp.accepted           = 1'b1;
            rsp.probe_request      = 1'b1;
            rsp.probe_code         = vbc_pkg::CODE_START;
         end
      end else if (state.busy) begin
         rsp.accepted = 1'b1;
         case (state.phase)
            vbc_pkg::PH_SEARCH: begin
               state_next.centre_dev  = dev;
               state_next.search_code = stepped_code;
               state_next.step_size   = next_step;
               rsp.probe_request      = 1'b1;
               rsp.probe_entry        = state.entry;
               if (next_step != '0) begin
                  rsp.probe_code = stepped_code;
               end else begin
                  state_next.phase = vbc_pkg::PH_LOWER;
                  rsp.probe_code   = vbc_pkg::lower_of(stepped_code);
               end
            end
            vbc_pkg::PH_LOWER: begin
               state_next.lower_dev = dev;
               state_next.phase     = vbc_pkg::PH_UPPER;
               rsp.probe_request    = 1'b1;
               rsp.probe_entry      = state.entry;
               rsp.probe_code       = code_high;
            end
            default: begin
               if (state.entry) begin
                  state_next.code_second = pick;
               end else begin
                  state_next.code_first = pick;
               end
               state_next.phase       = vbc_pkg::PH_SEARCH;
               state_next.search_code = vbc_pkg::CODE_START;
               state_next.step_size   = vbc_pkg::STEP_START;
               if (!state.entry) begin
                  state_next.entry  = 1'b1;
                  rsp.probe_request = 1'b1;
                  rsp.probe_entry   = 1'b1;
                  rsp.probe_code    = vbc_pkg::CODE_START;
               end else begin
                  state_next.entry = 1'b0;
                  state_next.busy  = 1'b0;
                  rsp.done_res     = 1'b1;
               end
            end
         endcase
      end

      rsp.code_first  = state_next.code_first;
      rsp.code_second = state_next.code_second;
   end

endmodule

### dv/vco_band_calibration_test.sv
// Self-checking testbench for the VCO band calibration block, with its own predictor.
module vco_band_calibration_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Run sizing. The cycle cap is far above the slowest correct run: about
   // 2000 items, each waiting out sender gaps and receiver stalls near 72%.
   localparam int RUN_LIMIT     = 400000;
   localparam int SETTLE_CYCLES = 4;     // two pipeline registers, plus margin
   localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
   localparam int PHASE_ITEMS   = 450;   // accepted items per random phase

   // One row of the directed script. Rows with known set carry a result that
   // can be read straight off the spec; the rest go through the predictor.
   typedef struct packed {
      logic                            func;
      logic [vbc_pkg::COUNT_WIDTH-1:0] count;
      logic                            known;
      vbc_pkg::rsp_type                want;
   } script_row_type;

   localparam vbc_pkg::rsp_type IGNORED_FRESH = '0;

   localparam script_row_type SCRIPT [24] = '{
      // count while idle right after reset
      '{vbc_pkg::FUNC_COUNT, 12'd0,    1'b1, IGNORED_FRESH},
      '{vbc_pkg::FUNC_START, 12'd0,    1'b1,
        '{1'b1, 5'd16, 1'b0, 1'b1, 1'b0, 5'd0, 5'd0}},
      // start while busy
      '{vbc_pkg::FUNC_START, 12'd4095, 1'b1, IGNORED_FRESH},
      // first target search: below, above, equal, below
      '{vbc_pkg::FUNC_COUNT, 12'd0,    1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd4095, 1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd2001, 1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd0,    1'b0, IGNORED_FRESH},
      // both neighbors exact: tie goes to the lower one
      '{vbc_pkg::FUNC_COUNT, 12'd2001, 1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd2001, 1'b0, IGNORED_FRESH},
      // second target driven to the top code, upper neighbor clamps
      '{vbc_pkg::FUNC_COUNT, 12'd0,    1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd0,    1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd0,    1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd0,    1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd0,    1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd1834, 1'b0, IGNORED_FRESH},
      // finished: codes stay visible, then restart
      '{vbc_pkg::FUNC_COUNT, 12'd4095, 1'b1,
        '{1'b0, 5'd0, 1'b0, 1'b0, 1'b0, 5'd20, 5'd31}},
      '{vbc_pkg::FUNC_START, 12'd0,    1'b1,
        '{1'b1, 5'd16, 1'b0, 1'b1, 1'b0, 5'd20, 5'd31}},
      // first target driven to the bottom, lower neighbor reaches zero
      '{vbc_pkg::FUNC_COUNT, 12'd4095, 1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd4095, 1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd4095, 1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd4095, 1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd4095, 1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_COUNT, 12'd0,    1'b0, IGNORED_FRESH},
      '{vbc_pkg::FUNC_START, 12'd0,    1'b0, IGNORED_FRESH}
   };

   // DUT ports. Every input starts at a known value.
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_func = vbc_pkg::FUNC_START;
   logic [vbc_pkg::COUNT_WIDTH-1:0] req_measured_count = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_probe_request;
   logic [vbc_pkg::CODE_WIDTH-1:0]  rsp_probe_code;
   logic                            rsp_probe_entry;
   logic                            rsp_accepted;
   logic                            rsp_done_res;
   logic [vbc_pkg::CODE_WIDTH-1:0]  rsp_code_first;
   logic [vbc_pkg::CODE_WIDTH-1:0]  rsp_code_second;
   logic                            csr_write_enable = 1'b0;
   logic                            csr_index = vbc_pkg::CSR_TARGET_FIRST;
   logic [vbc_pkg::COUNT_WIDTH-1:0] csr_write_data = '0;

   vco_band_calibration dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_measured_count (req_measured_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_probe_request  (rsp_probe_request),
      .rsp_probe_code     (rsp_probe_code),
      .rsp_probe_entry    (rsp_probe_entry),
      .rsp_accepted       (rsp_accepted),
      .rsp_done_res       (rsp_done_res),
      .rsp_code_first     (rsp_code_first),
      .rsp_code_second    (rsp_code_second),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // Predictor copy of the calibration state and the target registers.
   logic [vbc_pkg::COUNT_WIDTH-1:0] target_first  = vbc_pkg::TARGET_FIRST_RESET;
   logic [vbc_pkg::COUNT_WIDTH-1:0] target_second = vbc_pkg::TARGET_SECOND_RESET;
   logic                            cal_busy   = 1'b0;
   logic                            cal_entry  = 1'b0;
   vbc_pkg::phase_type              cal_stage  = vbc_pkg::PH_SEARCH;
   logic [vbc_pkg::CODE_WIDTH-1:0]  cal_code   = vbc_pkg::CODE_START;
   logic [vbc_pkg::STEP_WIDTH-1:0]  cal_step   = vbc_pkg::STEP_START;
   logic [vbc_pkg::COUNT_WIDTH-1:0] centre_gap = '0;
   logic [vbc_pkg::COUNT_WIDTH-1:0] lower_gap  = '0;
   logic [vbc_pkg::CODE_WIDTH-1:0]  chosen_code [2] = '{'0, '0};

   vbc_pkg::rsp_type calibration_replies [$];   // expected results, oldest first
   int      accepted_items = 0;        // transfers the block acts on
   int      mismatches = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      holds_asked = 0;

   // Free-running clock, 2 ns period.
   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop: count cycles and give up at the cap.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("vco_band_calibration_test: errors");
      $finish;
   end

   function automatic logic [vbc_pkg::CODE_WIDTH-1:0] clamp_down(
         input logic [vbc_pkg::CODE_WIDTH-1:0] c);
      return (c == '0) ? '0 : c - vbc_pkg::CODE_WIDTH'(1);
   endfunction

   function automatic logic [vbc_pkg::CODE_WIDTH-1:0] clamp_up(
         input logic [vbc_pkg::CODE_WIDTH-1:0] c);
      return (c == vbc_pkg::CODE_MAX) ? vbc_pkg::CODE_MAX : c + vbc_pkg::CODE_WIDTH'(1);
   endfunction

   // Advance the predicted calibration by one accepted transfer and return
   // the result the block must give for it.
   function automatic vbc_pkg::rsp_type calibrate(input logic func,
         input logic [vbc_pkg::COUNT_WIDTH-1:0] count);
      vbc_pkg::rsp_type                r;
      logic [vbc_pkg::COUNT_WIDTH-1:0] aim;
      logic [vbc_pkg::COUNT_WIDTH-1:0] gap;
      logic [vbc_pkg::CODE_WIDTH-1:0]  keep;
      r = '0;
      if (func == vbc_pkg::FUNC_START) begin
         // a start only counts when no sequence is running
         if (!cal_busy) begin
            cal_busy  = 1'b1;
            cal_entry = 1'b0;
            cal_stage = vbc_pkg::PH_SEARCH;
            cal_code  = vbc_pkg::CODE_START;
            cal_step  = vbc_pkg::STEP_START;
            r.accepted      = 1'b1;
            r.probe_request = 1'b1;
            r.probe_code    = cal_code;
         end
      end else if (cal_busy) begin
         aim = cal_entry ? target_second : target_first;
         gap = (count < aim) ? aim - count : count - aim;
         r.accepted      = 1'b1;
         r.probe_request = 1'b1;
         r.probe_entry   = cal_entry;
         case (cal_stage)
            vbc_pkg::PH_SEARCH: begin
               centre_gap = gap;
               if (count < aim) begin
                  cal_code = cal_code + vbc_pkg::CODE_WIDTH'(cal_step);
               end else if (count > aim) begin
                  cal_code = cal_code - vbc_pkg::CODE_WIDTH'(cal_step);
               end
               cal_step = cal_step >> 1;
               if (cal_step != '0) begin
                  r.probe_code = cal_code;
               end else begin
                  cal_stage    = vbc_pkg::PH_LOWER;
                  r.probe_code = clamp_down(cal_code);
               end
            end
            vbc_pkg::PH_LOWER: begin
               lower_gap    = gap;
               cal_stage    = vbc_pkg::PH_UPPER;
               r.probe_code = clamp_up(cal_code);
            end
            default: begin
               // smallest deviation wins; ties prefer lower, then upper
               if (lower_gap <= centre_gap && lower_gap <= gap) begin
                  keep = clamp_down(cal_code);
               end else if (gap <= centre_gap && gap <= lower_gap) begin
                  keep = clamp_up(cal_code);
               end else begin
                  keep = cal_code;
               end
               chosen_code[cal_entry] = keep;
               cal_stage = vbc_pkg::PH_SEARCH;
               cal_code  = vbc_pkg::CODE_START;
               cal_step  = vbc_pkg::STEP_START;
               if (!cal_entry) begin
                  cal_entry     = 1'b1;
                  r.probe_entry = 1'b1;
                  r.probe_code  = cal_code;
               end else begin
                  cal_busy        = 1'b0;
                  cal_entry       = 1'b0;
                  r.probe_request = 1'b0;
                  r.probe_entry   = 1'b0;
                  r.done_res      = 1'b1;
               end
            end
         endcase
      end
      r.code_first  = chosen_code[0];
      r.code_second = chosen_code[1];
      return r;
   endfunction

   // Pick a measured count for the current target: mostly exact or near it,
   // so ties and small deviations come up often, with extremes and noise.
   function automatic logic [vbc_pkg::COUNT_WIDTH-1:0] aimed_count();
      logic [vbc_pkg::COUNT_WIDTH-1:0] aim;
      aim = cal_entry ? target_second : target_first;
      case ($urandom_range(9))
         0, 1, 2: return aim;
         3, 4:    return aim + vbc_pkg::COUNT_WIDTH'($urandom_range(1, 3));
         5:       return aim - vbc_pkg::COUNT_WIDTH'($urandom_range(1, 3));
         6:       return '0;
         7:       return '1;
         default: return vbc_pkg::COUNT_WIDTH'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h expected %0h", field, got, want));
      end
   endtask

   // Offer one item from a falling edge and hold it until the transfer.
   // Predict at the accepting edge; known rows queue their typed result.
   task automatic send_item(input logic func, input logic [vbc_pkg::COUNT_WIDTH-1:0] count,
                            input logic known, input vbc_pkg::rsp_type want);
      vbc_pkg::rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_func           <= func;
      req_measured_count <= count;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = calibrate(func, count);
      if (predicted.accepted) begin
         accepted_items++;
      end
      calibration_replies.push_back(known ? want : predicted);
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding result, then let the
   // pipeline settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (calibration_replies.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_target(input logic index,
                               input logic [vbc_pkg::COUNT_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      if (index == vbc_pkg::CSR_TARGET_FIRST) begin
         target_first = value;
      end else begin
         target_second = value;
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // One random phase. Most items follow the calibration protocol with
   // random counts; about one in eight is noise (stray starts, counts
   // while idle, arbitrary values). Midway, ask the receiver for a long
   // hold-off while items keep coming; at a quarter, pause until drained.
   // Close the running sequence and drain so registers can be rewritten.
   task automatic run_phase(input int send_pct, input int recv_pct);
      int  goal;
      bit  paused;
      bit  held;
      goal   = accepted_items + PHASE_ITEMS;
      paused = 1'b0;
      held   = 1'b0;
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
      while (accepted_items < goal) begin
         if (!paused && accepted_items >= goal - 3 * PHASE_ITEMS / 4) begin
            paused = 1'b1;
            wait_drained();
         end
         if (!held && accepted_items >= goal - PHASE_ITEMS / 2) begin
            held = 1'b1;
            holds_asked++;
         end
         if ($urandom_range(7) == 0) begin
            send_item(1'($urandom), vbc_pkg::COUNT_WIDTH'($urandom), 1'b0, IGNORED_FRESH);
         end else if (!cal_busy) begin
            send_item(vbc_pkg::FUNC_START, vbc_pkg::COUNT_WIDTH'($urandom), 1'b0,
                      IGNORED_FRESH);
         end else begin
            send_item(vbc_pkg::FUNC_COUNT, aimed_count(), 1'b0, IGNORED_FRESH);
         end
      end
      while (cal_busy) begin
         send_item(vbc_pkg::FUNC_COUNT, aimed_count(), 1'b0, IGNORED_FRESH);
      end
      wait_drained();
   endtask

   // Receiver: random stall at the phase's rate, or a long hold-off when
   // asked, counted here so the sender keeps offering meanwhile.
   initial begin
      int hold_left;
      int holds_given;
      hold_left   = 0;
      holds_given = 0;
      forever begin
         @(negedge clock);
         if (holds_given != holds_asked) begin
            holds_given = holds_asked;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Compare every result transfer with the oldest expectation.
   always @(posedge clock) begin : compare_replies
      vbc_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (calibration_replies.size() == 0) begin
            report_mismatch("result with no expectation waiting");
         end else begin
            want = calibration_replies.pop_front();
            check_field("probe_request", 8'(rsp_probe_request), 8'(want.probe_request));
            check_field("probe_code", 8'(rsp_probe_code), 8'(want.probe_code));
            check_field("probe_entry", 8'(rsp_probe_entry), 8'(want.probe_entry));
            check_field("accepted", 8'(rsp_accepted), 8'(want.accepted));
            check_field("done_res", 8'(rsp_done_res), 8'(want.done_res));
            check_field("code_first", 8'(rsp_code_first), 8'(want.code_first));
            check_field("code_second", 8'(rsp_code_second), 8'(want.code_second));
         end
      end
   end

   // Main sequence: reset, directed script, then random phases at
   // different target settings and idling mixes.
   initial begin
      int row;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < $size(SCRIPT); row++) begin
         send_item(SCRIPT[row].func, SCRIPT[row].count, SCRIPT[row].known, SCRIPT[row].want);
      end

      // reset targets, no idling on either side
      run_phase(0, 0);

      // extremes: no count below the first target or above the second
      write_target(vbc_pkg::CSR_TARGET_FIRST, '0);
      write_target(vbc_pkg::CSR_TARGET_SECOND, '1);
      run_phase(72, 0);

      write_target(vbc_pkg::CSR_TARGET_FIRST, '1);
      write_target(vbc_pkg::CSR_TARGET_SECOND, '0);
      run_phase(0, 72);

      write_target(vbc_pkg::CSR_TARGET_FIRST, vbc_pkg::COUNT_WIDTH'($urandom));
      write_target(vbc_pkg::CSR_TARGET_SECOND, vbc_pkg::COUNT_WIDTH'($urandom));
      run_phase(21, 21);

      if (mismatches == 0 && calibration_replies.size() == 0) begin
         $display("vco_band_calibration_test: clean");
      end else begin
         $display("vco_band_calibration_test: errors");
      end
      $finish;
   end

endmodule
